[sv/qsel_pkg.sv]
// qsel_pkg: shared types and codes for the quickselect block
// no dependencies
`timescale 1ns / 1ps

package qsel_pkg;

    localparam int unsigned ValueWidth  = 32;
    localparam int unsigned RankWidth   = 11;
    localparam int unsigned ActionWidth = 2;
    localparam int unsigned StatusWidth = 2;

    typedef enum logic [ActionWidth-1:0] {
        ACT_CLEAR  = 2'd0,
        ACT_LOAD   = 2'd1,
        ACT_SELECT = 2'd2,
        ACT_NONE   = 2'd3
    } t_action;

    typedef enum logic [StatusWidth-1:0] {
        ST_OK       = 2'd0,
        ST_RANGE    = 2'd1,
        ST_OVERFLOW = 2'd2,
        ST_SPARE    = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PIV_RD,
        S_PIV_USE,
        S_RSCAN_RD,
        S_RSCAN_USE,
        S_LSCAN_RD,
        S_LSCAN_USE,
        S_FINAL,
        S_EMIT
    } t_state;

endpackage

[sv/qsel_if.sv]
// qsel_in_if / qsel_out_if: valid-ready channels for the quickselect block
// depends on qsel_pkg
`timescale 1ns / 1ps

interface qsel_in_if;
    logic                                          valid;
    logic                                          ready;
    logic [qsel_pkg::ActionWidth-1:0]              action;
    logic signed [qsel_pkg::ValueWidth-1:0]        value;
    logic [qsel_pkg::RankWidth-1:0]                rank;

    modport source (output valid, action, value, rank, input ready);
    modport sink   (input valid, action, value, rank, output ready);
endinterface

interface qsel_out_if;
    logic                                          valid;
    logic                                          ready;
    logic signed [qsel_pkg::ValueWidth-1:0]        selected;
    logic [qsel_pkg::StatusWidth-1:0]              status;

    modport source (output valid, selected, status, input ready);
    modport sink   (input valid, selected, status, output ready);
endinterface

[sv/qsel_ram.sv]
// qsel_ram: generic single write port, single read port ram, registered read
// no dependencies
`timescale 1ns / 1ps

module qsel_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[sv/quickselect_kth_smallest.sv]
// quickselect_kth_smallest: k-th smallest value of a loaded set, by quickselect
// depends on qsel_pkg, qsel_if (qsel_in_if, qsel_out_if) and qsel_ram
// clear and load transactions are accepted back to back while the block is idle.
// a select that is not flagged runs hole-partition rounds over the value ram, which
// has one read port and a registered read; each round keeps the side that holds k.
// the result waits in an output register.
// synchronous active-low reset empties the set; the ram needs no clearing.
`timescale 1ns / 1ps

module quickselect_kth_smallest #(
    parameter int unsigned STORE_DEPTH = 1024
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    qsel_in_if.sink       i_in,
    qsel_out_if.source    o_out
);

    localparam int unsigned AW   = $clog2(STORE_DEPTH);
    localparam int unsigned CW   = $clog2(STORE_DEPTH + 1);
    localparam int unsigned CMPW = (CW > qsel_pkg::RankWidth) ? CW : qsel_pkg::RankWidth;
    localparam int unsigned VW   = qsel_pkg::ValueWidth;

    // control state
    qsel_pkg::t_state r_state, n_state;
    logic [CW-1:0]    r_count;
    logic             r_ovf;
    logic             r_out_valid;

    // partition datapath: window [lo, hi], scan pointers l and r, target k
    logic [AW-1:0]           r_lo, r_hi, r_l, r_r, r_k;
    logic signed [VW-1:0]    r_pivot;
    logic signed [VW-1:0]    r_res;
    logic [qsel_pkg::StatusWidth-1:0] r_res_status;
    logic signed [VW-1:0]    r_out_sel;
    logic [qsel_pkg::StatusWidth-1:0] r_out_status;

    // ram port
    logic                 ram_we, ram_re;
    logic [AW-1:0]        ram_waddr, ram_raddr;
    logic [VW-1:0]        ram_wdata;
    logic [VW-1:0]        ram_rdata_u;
    logic signed [VW-1:0] ram_rdata;

    logic             in_fire;
    logic             out_free;
    logic             rank_bad;
    logic [CMPW-1:0]  rank_ext, count_ext;
    logic [qsel_pkg::RankWidth-1:0] rank_m1;
    logic             l_lt_r;
    logic             hit;

    qsel_ram #(
        .WIDTH (VW),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata_u)
    );

    assign ram_rdata = $signed(ram_rdata_u);
    assign in_fire   = i_in.valid && i_in.ready;
    // the output register takes a new result when empty or being drained
    assign out_free  = !r_out_valid || o_out.ready;
    assign rank_ext  = CMPW'(i_in.rank);
    assign count_ext = CMPW'(r_count);
    assign rank_bad  = (i_in.rank == '0) || (rank_ext > count_ext);
    assign rank_m1   = i_in.rank - qsel_pkg::RankWidth'(1);
    assign l_lt_r    = r_l < r_r;
    assign hit       = r_l == r_k;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            qsel_pkg::S_IDLE: begin
                if (in_fire && i_in.action == qsel_pkg::ACT_SELECT) begin
                    if (r_ovf || rank_bad) begin
                        n_state = qsel_pkg::S_EMIT;
                    end else begin
                        n_state = qsel_pkg::S_PIV_RD;
                    end
                end
            end
            qsel_pkg::S_PIV_RD:  n_state = qsel_pkg::S_PIV_USE;
            qsel_pkg::S_PIV_USE: n_state = qsel_pkg::S_RSCAN_RD;
            qsel_pkg::S_RSCAN_RD: begin
                n_state = l_lt_r ? qsel_pkg::S_RSCAN_USE : qsel_pkg::S_FINAL;
            end
            qsel_pkg::S_RSCAN_USE: begin
                n_state = (ram_rdata >= r_pivot) ? qsel_pkg::S_RSCAN_RD
                                                 : qsel_pkg::S_LSCAN_RD;
            end
            qsel_pkg::S_LSCAN_RD: begin
                n_state = l_lt_r ? qsel_pkg::S_LSCAN_USE : qsel_pkg::S_FINAL;
            end
            qsel_pkg::S_LSCAN_USE: begin
                n_state = (ram_rdata <= r_pivot) ? qsel_pkg::S_LSCAN_RD
                                                 : qsel_pkg::S_RSCAN_RD;
            end
            qsel_pkg::S_FINAL: begin
                n_state = hit ? qsel_pkg::S_EMIT : qsel_pkg::S_PIV_RD;
            end
            qsel_pkg::S_EMIT: begin
                if (out_free) begin
                    n_state = qsel_pkg::S_IDLE;
                end
            end
            default: n_state = qsel_pkg::S_IDLE;
        endcase
    end

    // ram controls and handshake
    always_comb begin
        ram_we     = 1'b0;
        ram_waddr  = r_l;
        ram_wdata  = ram_rdata_u;
        ram_re     = 1'b0;
        ram_raddr  = r_r;
        i_in.ready = 1'b0;
        unique case (r_state)
            qsel_pkg::S_IDLE: begin
                i_in.ready = 1'b1;
                // append on load while there is room (ready is high here)
                ram_we    = i_in.valid && i_in.action == qsel_pkg::ACT_LOAD &&
                            (count_ext < CMPW'(STORE_DEPTH));
                ram_waddr = r_count[AW-1:0];
                ram_wdata = i_in.value;
            end
            qsel_pkg::S_PIV_RD: begin
                ram_re    = 1'b1;
                ram_raddr = r_lo;
            end
            qsel_pkg::S_RSCAN_RD: begin
                ram_re    = l_lt_r;
                ram_raddr = r_r;
            end
            qsel_pkg::S_RSCAN_USE: begin
                // smaller element from the right fills the hole at l
                ram_we    = ram_rdata < r_pivot;
                ram_waddr = r_l;
            end
            qsel_pkg::S_LSCAN_RD: begin
                ram_re    = l_lt_r;
                ram_raddr = r_l;
            end
            qsel_pkg::S_LSCAN_USE: begin
                // larger element from the left fills the hole at r
                ram_we    = ram_rdata > r_pivot;
                ram_waddr = r_r;
            end
            qsel_pkg::S_FINAL: begin
                ram_we    = 1'b1;
                ram_waddr = r_l;
                ram_wdata = r_pivot;
            end
            qsel_pkg::S_PIV_USE, qsel_pkg::S_EMIT: begin
                ram_we = 1'b0;
            end
            default: ram_we = 1'b0;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= qsel_pkg::S_IDLE;
            r_count     <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == qsel_pkg::S_IDLE && in_fire) begin
                unique case (i_in.action)
                    qsel_pkg::ACT_CLEAR: begin
                        r_count <= '0;
                        r_ovf   <= 1'b0;
                    end
                    qsel_pkg::ACT_LOAD: begin
                        if (count_ext < CMPW'(STORE_DEPTH)) begin
                            r_count <= r_count + CW'(1);
                        end else begin
                            r_ovf <= 1'b1;
                        end
                    end
                    qsel_pkg::ACT_SELECT: begin
                        // an overflow report consumes the flag
                        r_ovf <= 1'b0;
                    end
                    default: r_ovf <= r_ovf;
                endcase
            end
            if (r_state == qsel_pkg::S_EMIT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // partition datapath
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            qsel_pkg::S_IDLE: begin
                r_lo         <= '0;
                r_hi         <= AW'(r_count - CW'(1));
                r_k          <= AW'(rank_m1);
                r_res        <= '0;
                r_res_status <= r_ovf ? qsel_pkg::ST_OVERFLOW :
                                rank_bad ? qsel_pkg::ST_RANGE : qsel_pkg::ST_OK;
            end
            qsel_pkg::S_PIV_USE: begin
                r_pivot <= ram_rdata;
                r_l     <= r_lo;
                r_r     <= r_hi;
            end
            qsel_pkg::S_RSCAN_USE: begin
                if (ram_rdata >= r_pivot) begin
                    r_r <= r_r - AW'(1);
                end else begin
                    r_l <= r_l + AW'(1);
                end
            end
            qsel_pkg::S_LSCAN_USE: begin
                if (ram_rdata <= r_pivot) begin
                    r_l <= r_l + AW'(1);
                end else begin
                    r_r <= r_r - AW'(1);
                end
            end
            qsel_pkg::S_FINAL: begin
                // pivot settled at l: done, or keep the side that holds k
                if (hit) begin
                    r_res <= r_pivot;
                end else if (r_l < r_k) begin
                    r_lo <= r_l + AW'(1);
                end else begin
                    r_hi <= r_l - AW'(1);
                end
            end
            qsel_pkg::S_EMIT: begin
                if (out_free) begin
                    r_out_sel    <= r_res;
                    r_out_status <= r_res_status;
                end
            end
            qsel_pkg::S_PIV_RD, qsel_pkg::S_RSCAN_RD, qsel_pkg::S_LSCAN_RD: begin
                r_pivot <= r_pivot;
            end
            default: r_pivot <= r_pivot;
        endcase
    end

    assign o_out.valid    = r_out_valid;
    assign o_out.selected = r_out_sel;
    assign o_out.status   = r_out_status;

    // the target rank stays inside the active window during a select
    a_k_in_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == qsel_pkg::S_PIV_RD || r_state == qsel_pkg::S_FINAL) |->
            (r_lo <= r_k && r_k <= r_hi))
        else $error("rank left the partition window");

    // scan pointers never cross the window
    a_scan_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == qsel_pkg::S_RSCAN_USE || r_state == qsel_pkg::S_LSCAN_USE) |->
            (r_lo <= r_l && r_l < r_r && r_r <= r_hi))
        else $error("scan pointer outside window");

    // a flagged result carries a zero value
    a_flag_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.status != qsel_pkg::ST_OK) |-> (o_out.selected == '0))
        else $error("flagged result with nonzero value");

    // fill count never exceeds the store
    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        count_ext <= CMPW'(STORE_DEPTH))
        else $error("element count overran the store");

endmodule

[tb/tb_quickselect_kth_smallest.sv]
// tb_quickselect_kth_smallest: self-checking bench for the quickselect block
// drives clear/load/select transactions, predicts each select result, checks the output
// depends on qsel_pkg, qsel_if and quickselect_kth_smallest
`timescale 1ns / 1ps

module tb_quickselect_kth_smallest;

    localparam int Depth = 1024;

    typedef struct {
        logic signed [qsel_pkg::ValueWidth-1:0] selected;
        logic [qsel_pkg::StatusWidth-1:0]       status;
    } t_pick;

    // one row of the directed table; typed rows carry a hand-computed result
    typedef struct {
        qsel_pkg::t_action                      action;
        logic signed [qsel_pkg::ValueWidth-1:0] value;
        logic [qsel_pkg::RankWidth-1:0]         rank;
        bit                                     typed;
        logic signed [qsel_pkg::ValueWidth-1:0] selected;
        logic [qsel_pkg::StatusWidth-1:0]       status;
    } t_row;

    logic i_clk;
    logic i_rst_n;

    qsel_in_if  in_ch();
    qsel_out_if out_ch();

    quickselect_kth_smallest #(.STORE_DEPTH(Depth)) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    // shadow of the block's state
    logic signed [qsel_pkg::ValueWidth-1:0] shadow_store [Depth];
    int                                     shadow_count;
    bit                                     shadow_dropped;

    t_pick pending_picks [$];
    int    fail_count;
    int    sent_count;
    bit    calm;

    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    // hole partition over [lo, hi] of the shadow store, returns the pivot slot
    function automatic int partition_window(int lo, int hi);
        logic signed [qsel_pkg::ValueWidth-1:0] pivot;
        int l;
        int r;
        pivot = shadow_store[lo];
        l = lo;
        r = hi;
        while (l < r) begin
            while (l < r && shadow_store[r] >= pivot) r--;
            shadow_store[l] = shadow_store[r];
            while (l < r && shadow_store[l] <= pivot) l++;
            shadow_store[r] = shadow_store[l];
        end
        shadow_store[l] = pivot;
        return l;
    endfunction

    // updates the shadow state; returns 1 when the transaction yields a result
    function automatic bit predict_pick(qsel_pkg::t_action act,
                                        logic signed [qsel_pkg::ValueWidth-1:0] val,
                                        logic [qsel_pkg::RankWidth-1:0] rank,
                                        output t_pick pick);
        int lo;
        int hi;
        int p;
        int k;
        pick.selected = '0;
        pick.status   = qsel_pkg::ST_OK;
        case (act)
            qsel_pkg::ACT_CLEAR: begin
                shadow_count   = 0;
                shadow_dropped = 1'b0;
                return 1'b0;
            end
            qsel_pkg::ACT_LOAD: begin
                if (shadow_count < Depth) begin
                    shadow_store[shadow_count] = val;
                    shadow_count++;
                end else begin
                    shadow_dropped = 1'b1;
                end
                return 1'b0;
            end
            qsel_pkg::ACT_SELECT: begin
                // dropped loads win over a bad rank
                if (shadow_dropped) begin
                    shadow_dropped = 1'b0;
                    pick.status = qsel_pkg::ST_OVERFLOW;
                end else if (rank == 0 || int'(rank) > shadow_count) begin
                    pick.status = qsel_pkg::ST_RANGE;
                end else begin
                    k  = int'(rank) - 1;
                    lo = 0;
                    hi = shadow_count - 1;
                    forever begin
                        p = partition_window(lo, hi);
                        if (p == k) break;
                        if (p < k) lo = p + 1;
                        else hi = p - 1;
                    end
                    pick.selected = shadow_store[k];
                end
                return 1'b1;
            end
            default: return 1'b0;
        endcase
    endfunction

    // mostly short gaps, a few long ones, none at all in calm stretches
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(5, 40);
    endfunction

    // drive one transaction, wait for the handshake, then update the prediction
    task automatic send(qsel_pkg::t_action act,
                        logic signed [qsel_pkg::ValueWidth-1:0] val,
                        logic [qsel_pkg::RankWidth-1:0] rank, bit typed = 1'b0,
                        t_pick typed_pick = '{default: '0});
        int    gap;
        t_pick pick;
        bit    has_pick;
        gap = pick_gap();
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid  <= 1'b1;
        in_ch.action <= act;
        in_ch.value  <= val;
        in_ch.rank   <= rank;
        do @(posedge i_clk); while (!(in_ch.valid && in_ch.ready));
        has_pick = predict_pick(act, val, rank, pick);
        if (has_pick) pending_picks.push_back(typed ? typed_pick : pick);
        sent_count++;
    endtask

    // one value in a given style: full range, duplicates, extremes
    function automatic logic signed [qsel_pkg::ValueWidth-1:0] draw_value(int style);
        case (style)
            1: return $signed(32'($urandom_range(0, 8)) - 32'sd4);
            2: return ($urandom_range(0, 1)) ? 32'sh7fffffff : 32'sh80000000;
            default: return $signed($urandom());
        endcase
    endfunction

    task automatic load_set(int n, int style);
        logic signed [qsel_pkg::ValueWidth-1:0] v;
        int i;
        v = $signed(32'($urandom_range(0, 1000))) - 32'sd500;
        for (i = 0; i < n; i++) begin
            if (style == 3) v = v + $signed(32'($urandom_range(0, 5)));      // ascending
            else if (style == 4) v = v - $signed(32'($urandom_range(0, 5))); // descending
            else v = draw_value(style);
            send(qsel_pkg::ACT_LOAD, v, qsel_pkg::RankWidth'($urandom()));
        end
    endtask

    task automatic select_some(int m);
        logic [qsel_pkg::RankWidth-1:0] rank;
        int r;
        repeat (m) begin
            r = $urandom_range(0, 99);
            if (r < 5) rank = '0;
            else if (r < 10) rank = qsel_pkg::RankWidth'(shadow_count + 1);
            else if (r < 15) rank = qsel_pkg::RankWidth'($urandom());
            else if (shadow_count == 0) rank = qsel_pkg::RankWidth'($urandom_range(0, 3));
            else rank = qsel_pkg::RankWidth'($urandom_range(1, shadow_count));
            send(qsel_pkg::ACT_SELECT, $urandom(), rank);
            if ($urandom_range(0, 19) == 0) begin
                send(qsel_pkg::ACT_NONE, $urandom(), qsel_pkg::RankWidth'($urandom()));
            end
        end
    endtask

    // directed stimulus: empty store, extremes, bad ranks, ignored code, duplicates
    t_row directed [] = '{
        '{qsel_pkg::ACT_SELECT, 32'sd0,        11'd1,   1, 32'sd0,        qsel_pkg::ST_RANGE},
        '{qsel_pkg::ACT_LOAD,   32'sh7fffffff, 11'd0,   0, 32'sd0,        qsel_pkg::ST_OK},
        '{qsel_pkg::ACT_LOAD,   32'sh80000000, 11'h7ff, 0, 32'sd0,        qsel_pkg::ST_OK},
        '{qsel_pkg::ACT_LOAD,   32'sd0,        11'd0,   0, 32'sd0,        qsel_pkg::ST_OK},
        '{qsel_pkg::ACT_SELECT, 32'shffffffff, 11'd1,   1, 32'sh80000000, qsel_pkg::ST_OK},
        '{qsel_pkg::ACT_SELECT, 32'sd0,        11'd3,   1, 32'sh7fffffff, qsel_pkg::ST_OK},
        '{qsel_pkg::ACT_SELECT, 32'sd0,        11'd0,   1, 32'sd0,        qsel_pkg::ST_RANGE},
        '{qsel_pkg::ACT_SELECT, 32'sd0,        11'd4,   1, 32'sd0,        qsel_pkg::ST_RANGE},
        '{qsel_pkg::ACT_SELECT, 32'sd0,        11'h7ff, 1, 32'sd0,        qsel_pkg::ST_RANGE},
        '{qsel_pkg::ACT_NONE,   32'shffffffff, 11'h7ff, 0, 32'sd0,        qsel_pkg::ST_OK},
        '{qsel_pkg::ACT_SELECT, 32'sd0,        11'd2,   1, 32'sd0,        qsel_pkg::ST_OK},
        '{qsel_pkg::ACT_CLEAR,  32'sh55555555, 11'h555, 0, 32'sd0,        qsel_pkg::ST_OK},
        '{qsel_pkg::ACT_SELECT, 32'sd0,        11'd1,   1, 32'sd0,        qsel_pkg::ST_RANGE},
        '{qsel_pkg::ACT_LOAD,   32'sd5,        11'd0,   0, 32'sd0,        qsel_pkg::ST_OK},
        '{qsel_pkg::ACT_LOAD,   32'sd3,        11'd0,   0, 32'sd0,        qsel_pkg::ST_OK},
        '{qsel_pkg::ACT_LOAD,   32'sd3,        11'd0,   0, 32'sd0,        qsel_pkg::ST_OK},
        '{qsel_pkg::ACT_LOAD,   32'sd9,        11'd0,   0, 32'sd0,        qsel_pkg::ST_OK},
        '{qsel_pkg::ACT_LOAD,   -32'sd1,       11'd0,   0, 32'sd0,        qsel_pkg::ST_OK},
        '{qsel_pkg::ACT_LOAD,   32'sd3,        11'd0,   0, 32'sd0,        qsel_pkg::ST_OK},
        '{qsel_pkg::ACT_SELECT, 32'sd0,        11'd3,   0, 32'sd0,        qsel_pkg::ST_OK},
        '{qsel_pkg::ACT_SELECT, 32'sd0,        11'd6,   0, 32'sd0,        qsel_pkg::ST_OK},
        '{qsel_pkg::ACT_SELECT, 32'sd0,        11'd1,   0, 32'sd0,        qsel_pkg::ST_OK},
        '{qsel_pkg::ACT_SELECT, 32'sd0,        11'd4,   0, 32'sd0,        qsel_pkg::ST_OK},
        '{qsel_pkg::ACT_SELECT, 32'sd0,        11'd7,   1, 32'sd0,        qsel_pkg::ST_RANGE}
    };

    // stimulus
    initial begin
        int  n;
        int  style;
        t_pick tp;
        fail_count     = 0;
        sent_count     = 0;
        calm           = 1'b0;
        shadow_count   = 0;
        shadow_dropped = 1'b0;
        i_rst_n        = 1'b0;
        in_ch.valid    = 1'b0;
        in_ch.action   = qsel_pkg::ACT_NONE;
        in_ch.value    = '0;
        in_ch.rank     = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed[j]) begin
            tp.selected = directed[j].selected;
            tp.status   = directed[j].status;
            send(directed[j].action, directed[j].value, directed[j].rank,
                 directed[j].typed, tp);
        end

        // fill the store in chunks of mixed style, with selects on the way
        send(qsel_pkg::ACT_CLEAR, $urandom(), qsel_pkg::RankWidth'($urandom()));
        load_set(64, 0);
        while (shadow_count < Depth) begin
            calm  = ($urandom_range(0, 4) == 0);
            style = $urandom_range(0, 4);
            // sorted runs and duplicates are the slow case, so keep them short
            n = (style == 0) ? $urandom_range(20, 80) : $urandom_range(1, 24);
            if (shadow_count + n > Depth) n = Depth - shadow_count;
            load_set(n, style);
            if ($urandom_range(0, 1) == 0) select_some(1);
        end

        // loads into a full store are dropped and flagged at the next select
        calm = 1'b0;
        load_set(3, 0);
        select_some(1);
        select_some(2);
        load_set(1, 0);
        select_some(1);

        // short clear / load / select runs while the item budget lasts
        while (sent_count < 1050) begin
            calm = ($urandom_range(0, 4) == 0);
            if ($urandom_range(0, 99) < 85) begin
                send(qsel_pkg::ACT_CLEAR, $urandom(), qsel_pkg::RankWidth'($urandom()));
            end
            style = $urandom_range(0, 4);
            n = $urandom_range(1, 24);
            if (shadow_count + n > Depth) n = Depth - shadow_count;
            load_set(n, style);
            select_some($urandom_range(1, 3));
        end
        calm = 1'b0;
        in_ch.valid <= 1'b0;

        // drain, then let the block settle
        while (pending_picks.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    // result side backpressure: busy stretches broken by random stalls
    initial begin
        int busy;
        int stall;
        int r;
        out_ch.ready = 1'b0;
        forever begin
            busy = $urandom_range(1, 30);
            out_ch.ready <= 1'b1;
            repeat (busy) @(posedge i_clk);
            r = $urandom_range(0, 99);
            stall = (r < 30) ? 0 : (r < 90) ? $urandom_range(1, 3) : $urandom_range(5, 40);
            if (stall > 0) begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
        end
    end

    // check every accepted result transaction against the oldest prediction
    always @(posedge i_clk) begin
        t_pick want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (pending_picks.size() == 0) begin
                $error("unexpected result: selected %0d status %0d",
                       out_ch.selected, out_ch.status);
                fail_count++;
            end else begin
                want = pending_picks.pop_front();
                if (out_ch.selected !== want.selected) begin
                    $error("selected: expected %0d actual %0d", want.selected,
                           out_ch.selected);
                    fail_count++;
                end
                if (out_ch.status !== want.status) begin
                    $error("status: expected %0d actual %0d", want.status, out_ch.status);
                    fail_count++;
                end
            end
        end
    end

    // watchdog
    initial begin
        #10ms;
        $display("== FAIL ==");
        $finish;
    end

endmodule
